@@ sv/spv_pkg.sv @@
// ============================================================================
// spv_pkg - shared types and constants for the shader program validator
// Holds the beat formats, opcode and status codes, and the source-count
// table used by the classifier.
// ============================================================================
package spv_pkg;

    // Default sizes of the program resources.
    localparam int DEF_NUM_REGS     = 32;
    localparam int DEF_MAX_UNIFORMS = 64;
    localparam int DEF_MAX_ATTRIBS  = 16;
    localparam int DEF_MAX_TEXTURES = 8;
    localparam int DEF_MAX_VARYINGS = 8;
    localparam int DEF_MAX_INSTRS   = 256;

    // A matrix spans four consecutive uniforms; swizzle masks are one byte.
    localparam int MAT_SPAN = 4;
    localparam int SWZ_MAX  = 255;

    // Register indexes are carried at the width of the largest register file.
    localparam int REG_IDX_W = 6;
    localparam int IDX_W     = 9;

    // Depth of the queue between classifier and checker.
    localparam int QUEUE_DEPTH = 2;

    // Output counter saturates here.
    localparam logic [1:0] OCNT_SAT = 2'd2;

    localparam logic STAGE_VERTEX = 1'b0;
    localparam logic STAGE_PIXEL  = 1'b1;

    localparam logic [7:0] OPC_CONST    = 8'd0;
    localparam logic [7:0] OPC_INPUT    = 8'd1;
    localparam logic [7:0] OPC_UNIFORM  = 8'd2;
    localparam logic [7:0] OPC_MOV      = 8'd3;
    localparam logic [7:0] OPC_ADD      = 8'd4;
    localparam logic [7:0] OPC_SUB      = 8'd5;
    localparam logic [7:0] OPC_MUL      = 8'd6;
    localparam logic [7:0] OPC_MAD      = 8'd7;
    localparam logic [7:0] OPC_DOT3     = 8'd8;
    localparam logic [7:0] OPC_DOT4     = 8'd9;
    localparam logic [7:0] OPC_MIN      = 8'd10;
    localparam logic [7:0] OPC_MAX      = 8'd11;
    localparam logic [7:0] OPC_RCP      = 8'd12;
    localparam logic [7:0] OPC_RSQRT    = 8'd13;
    localparam logic [7:0] OPC_SIN      = 8'd14;
    localparam logic [7:0] OPC_COS      = 8'd15;
    localparam logic [7:0] OPC_TEX2D    = 8'd16;
    localparam logic [7:0] OPC_SWIZZLE  = 8'd17;
    localparam logic [7:0] OPC_MAT4     = 8'd18;
    localparam logic [7:0] OPC_SELECT   = 8'd19;
    localparam logic [7:0] OPC_POSITION = 8'd20;
    localparam logic [7:0] OPC_VARYING  = 8'd21;
    localparam logic [7:0] OPC_COLOR    = 8'd22;
    localparam logic [7:0] OPC_LAST     = OPC_COLOR;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_TOO_LONG    = 4'd1,
        ST_LIMITS      = 4'd2,
        ST_UNDEF_READ  = 4'd3,
        ST_NONFINITE   = 4'd4,
        ST_INPUT       = 4'd5,
        ST_MATRIX      = 4'd6,
        ST_TEXTURE     = 4'd7,
        ST_SWIZZLE     = 4'd8,
        ST_POSITION    = 4'd9,
        ST_COLOR       = 4'd10,
        ST_VARYING     = 4'd11,
        ST_OUT_COUNT   = 4'd12
    } status_t;

    // What a passing instruction does to the program state.
    typedef enum logic [1:0] {
        EFF_NONE   = 2'd0,
        EFF_WRITE  = 2'd1,
        EFF_OUTPUT = 2'd2
    } effect_t;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [15:0] dest_reg;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [15:0] operand_c;
        logic [31:0] lit_x;
        logic [31:0] lit_y;
        logic [31:0] lit_z;
        logic [31:0] lit_w;
        logic        end_of_program;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] error_index;
    } out_item_t;

    // Classified instruction as it travels from front to back.
    typedef struct packed {
        logic                 lim_err;
        logic [1:0]           nsrc;
        logic                 a_in_file;
        logic                 b_in_file;
        logic                 c_in_file;
        logic [REG_IDX_W-1:0] a_idx;
        logic [REG_IDX_W-1:0] b_idx;
        logic [REG_IDX_W-1:0] c_idx;
        logic [REG_IDX_W-1:0] dst_idx;
        status_t              late_status;
        effect_t              effect;
        logic                 eop;
    } ctrl_t;

    // Number of register sources an opcode reads.
    function automatic logic [1:0] src_count(input logic [7:0] op);
        logic [1:0] n;
        case (op)
            OPC_CONST, OPC_INPUT, OPC_UNIFORM:             n = 2'd0;
            OPC_MOV, OPC_RCP, OPC_RSQRT, OPC_SIN, OPC_COS: n = 2'd1;
            OPC_TEX2D, OPC_SWIZZLE, OPC_MAT4:              n = 2'd1;
            OPC_POSITION, OPC_VARYING, OPC_COLOR:          n = 2'd1;
            OPC_ADD, OPC_SUB, OPC_MUL, OPC_DOT3, OPC_DOT4: n = 2'd2;
            OPC_MIN, OPC_MAX:                              n = 2'd2;
            OPC_MAD, OPC_SELECT:                           n = 2'd3;
            default:                                       n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

@@ sv/shader_program_validator.sv @@
// ============================================================================
// shader_program_validator - streaming shader program checker
// Checks one shader instruction per beat and gives one verdict beat per
// program, on the instruction that ends it.
// ============================================================================
//
//  Channel  Direction  Handshake             Beat
//  -------  ---------  --------------------  ----------------------------------
//  cfg      in         cfg_valid/cfg_ready   stage bit (0 vertex, 1 pixel)
//  in       in         in_valid/in_stall     one instruction (in_item_t)
//  out      out        out_valid/out_stall   verdict: status, error_index
//
//  An instruction is checked at a rate of one per cycle while the queue
//  has room. The front stage classifies it in the cycle it is accepted and
//  writes it to a two-entry queue; the back stage checks it against the
//  program state once it reaches the head of the queue, and the verdict
//  for the final instruction is registered in the output register.
//  Reset (rst_n low, asynchronous) clears the stage to vertex and all
//  program state; no clearing pass follows.
//  A stalled output holds only verdict beats: ordinary instructions keep
//  flowing until a second end of program reaches the head of the queue,
//  and in_stall rises only when the queue is full.
//
module shader_program_validator
    import spv_pkg::*;
#(
    parameter int NUM_REGS     = DEF_NUM_REGS,
    parameter int MAX_UNIFORMS = DEF_MAX_UNIFORMS,
    parameter int MAX_ATTRIBS  = DEF_MAX_ATTRIBS,
    parameter int MAX_TEXTURES = DEF_MAX_TEXTURES,
    parameter int MAX_VARYINGS = DEF_MAX_VARYINGS,
    parameter int MAX_INSTRS   = DEF_MAX_INSTRS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    // Classified entry leaving the front stage.
    ctrl_t front_entry;
    // Entry at the head of the queue, offered to the back stage.
    ctrl_t head_entry;
    logic  q_full;
    logic  q_head_valid;
    logic  q_pop;
    logic  in_push;

    // The input side waits only when the queue has no room left.
    assign in_stall = q_full;
    assign in_push  = in_valid && !q_full;

    // The front stage owns the stage register and every check that does
    // not depend on earlier instructions of the program.
    spv_front #(
        .NUM_REGS     (NUM_REGS),
        .MAX_UNIFORMS (MAX_UNIFORMS),
        .MAX_ATTRIBS  (MAX_ATTRIBS),
        .MAX_TEXTURES (MAX_TEXTURES),
        .MAX_VARYINGS (MAX_VARYINGS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .entry     (front_entry)
    );

    spv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_push),
        .push_data  (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (head_entry)
    );

    // The back stage holds the written mask, position and output counts
    // and the first error, and registers the verdict beat.
    spv_back #(
        .NUM_REGS   (NUM_REGS),
        .MAX_INSTRS (MAX_INSTRS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (head_entry),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

@@ sv/spv_front.sv @@
// ============================================================================
// spv_front - instruction classifier
// Holds the stage register and runs every check that needs no program
// state, packing the outcome into one queue entry per accepted beat.
// ============================================================================
module spv_front
    import spv_pkg::*;
#(
    parameter int NUM_REGS     = DEF_NUM_REGS,
    parameter int MAX_UNIFORMS = DEF_MAX_UNIFORMS,
    parameter int MAX_ATTRIBS  = DEF_MAX_ATTRIBS,
    parameter int MAX_TEXTURES = DEF_MAX_TEXTURES,
    parameter int MAX_VARYINGS = DEF_MAX_VARYINGS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data,
    input  in_item_t in_data,
    output ctrl_t    entry
);

    logic       stage_reg;
    logic       stage_next;
    logic [7:0] op;
    logic [31:0] dst_w;
    logic [31:0] a_w;
    logic [31:0] b_w;
    logic [31:0] c_w;
    logic       lits_finite;

    assign cfg_ready  = 1'b1;
    assign stage_next = cfg_valid ? cfg_data : stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= STAGE_VERTEX;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign op    = in_data.opcode;
    assign dst_w = 32'(in_data.dest_reg);
    assign a_w   = 32'(in_data.operand_a);
    assign b_w   = 32'(in_data.operand_b);
    assign c_w   = 32'(in_data.operand_c);

    // An IEEE single is finite unless its exponent field is all ones.
    assign lits_finite = (in_data.lit_x[30:23] != 8'hFF) && (in_data.lit_y[30:23] != 8'hFF)
                      && (in_data.lit_z[30:23] != 8'hFF) && (in_data.lit_w[30:23] != 8'hFF);

    always_comb
    begin
        entry.lim_err = (op > OPC_LAST) || (dst_w >= 32'(NUM_REGS))
                     || (a_w >= 32'(MAX_UNIFORMS)) || (b_w >= 32'(MAX_UNIFORMS))
                     || (c_w >= 32'(MAX_UNIFORMS));
        entry.nsrc      = src_count(op);
        entry.a_in_file = a_w < 32'(NUM_REGS);
        entry.b_in_file = b_w < 32'(NUM_REGS);
        entry.c_in_file = c_w < 32'(NUM_REGS);
        entry.a_idx     = in_data.operand_a[REG_IDX_W-1:0];
        entry.b_idx     = in_data.operand_b[REG_IDX_W-1:0];
        entry.c_idx     = in_data.operand_c[REG_IDX_W-1:0];
        entry.dst_idx   = in_data.dest_reg[REG_IDX_W-1:0];
        entry.eop       = in_data.end_of_program;

        // Checks that follow the register reads, in priority order.
        entry.late_status = ST_OK;
        if ((op == OPC_CONST) && !lits_finite)
        begin
            entry.late_status = ST_NONFINITE;
        end
        else if ((op == OPC_INPUT) && (a_w >= 32'(MAX_ATTRIBS)))
        begin
            entry.late_status = ST_INPUT;
        end
        else if ((op == OPC_MAT4) && (b_w > 32'(MAX_UNIFORMS - MAT_SPAN)))
        begin
            entry.late_status = ST_MATRIX;
        end
        else if ((op == OPC_TEX2D)
                 && ((b_w >= 32'(MAX_TEXTURES)) || (stage_reg != STAGE_PIXEL)))
        begin
            entry.late_status = ST_TEXTURE;
        end
        else if ((op == OPC_SWIZZLE) && (b_w > 32'(SWZ_MAX)))
        begin
            entry.late_status = ST_SWIZZLE;
        end
        else if ((op == OPC_POSITION) && (stage_reg != STAGE_VERTEX))
        begin
            entry.late_status = ST_POSITION;
        end
        else if ((op == OPC_COLOR) && (stage_reg != STAGE_PIXEL))
        begin
            entry.late_status = ST_COLOR;
        end
        else if ((op == OPC_VARYING)
                 && ((stage_reg != STAGE_VERTEX) || (dst_w >= 32'(MAX_VARYINGS))))
        begin
            entry.late_status = ST_VARYING;
        end

        if ((op == OPC_POSITION) || (op == OPC_COLOR))
        begin
            entry.effect = EFF_OUTPUT;
        end
        else if (op == OPC_VARYING)
        begin
            entry.effect = EFF_NONE;
        end
        else
        begin
            entry.effect = EFF_WRITE;
        end
    end

endmodule

@@ sv/spv_queue.sv @@
// ============================================================================
// spv_queue - short queue between classifier and checker
// A small register FIFO that lets the input side and the checker stall
// independently.
// ============================================================================
module spv_queue
    import spv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  ctrl_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output ctrl_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ctrl_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/spv_back.sv @@
// ============================================================================
// spv_back - program state checker
// Applies the register-read checks against the written mask, tracks the
// program position, output count and first error, and drives the verdict
// beat through an output register.
// ============================================================================
module spv_back
    import spv_pkg::*;
#(
    parameter int NUM_REGS   = DEF_NUM_REGS,
    parameter int MAX_INSTRS = DEF_MAX_INSTRS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  ctrl_t     head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int RW   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int PC_W = $clog2(MAX_INSTRS + 2);
    localparam logic [PC_W-1:0] PC_LIMIT = PC_W'(MAX_INSTRS);

    logic [NUM_REGS-1:0] mask_reg;
    logic [NUM_REGS-1:0] mask_next;
    logic [1:0]          ocnt_reg;
    logic [1:0]          ocnt_next;
    logic [PC_W-1:0]     pc_reg;
    logic [PC_W-1:0]     pc_next;
    logic                disc_reg;
    logic                disc_next;
    status_t             err_st_reg;
    status_t             err_st_next;
    logic [PC_W-1:0]     err_idx_reg;
    logic [PC_W-1:0]     err_idx_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    out_item_t           out_data_reg;
    out_item_t           out_data_next;

    logic                a_ok;
    logic                b_ok;
    logic                c_ok;
    logic                undef_read;
    logic                active;
    status_t             step_status;
    logic [PC_W-1:0]     pc_step;
    logic [NUM_REGS-1:0] mask_step;
    logic [1:0]          ocnt_step;
    logic                disc_step;
    status_t             err_st_step;
    logic [PC_W-1:0]     err_idx_step;

    // A verdict beat may only be popped once the output register is free.
    assign pop = head_valid && (!head.eop || !out_valid_reg || !out_stall);

    assign a_ok = head.a_in_file && mask_reg[head.a_idx[RW-1:0]];
    assign b_ok = head.b_in_file && mask_reg[head.b_idx[RW-1:0]];
    assign c_ok = head.c_in_file && mask_reg[head.c_idx[RW-1:0]];
    assign undef_read = ((head.nsrc >= 2'd1) && !a_ok) || ((head.nsrc >= 2'd2) && !b_ok)
                     || ((head.nsrc == 2'd3) && !c_ok);

    always_comb
    begin
        if (head.lim_err)
        begin
            step_status = ST_LIMITS;
        end
        else if (undef_read)
        begin
            step_status = ST_UNDEF_READ;
        end
        else
        begin
            step_status = head.late_status;
        end

        pc_step      = (pc_reg <= PC_LIMIT) ? pc_reg + 1'b1 : pc_reg;
        active       = !disc_reg && (pc_step <= PC_LIMIT);
        mask_step    = mask_reg;
        ocnt_step    = ocnt_reg;
        disc_step    = disc_reg;
        err_st_step  = err_st_reg;
        err_idx_step = err_idx_reg;

        if (active && (step_status != ST_OK))
        begin
            disc_step    = 1'b1;
            err_st_step  = step_status;
            err_idx_step = pc_step;
        end
        else if (active)
        begin
            case (head.effect)
                EFF_WRITE:
                begin
                    mask_step[head.dst_idx[RW-1:0]] = 1'b1;
                end
                EFF_OUTPUT:
                begin
                    if (ocnt_reg < OCNT_SAT)
                    begin
                        ocnt_step = ocnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    mask_step = mask_reg;
                end
            endcase
        end

        mask_next      = mask_reg;
        ocnt_next      = ocnt_reg;
        pc_next        = pc_reg;
        disc_next      = disc_reg;
        err_st_next    = err_st_reg;
        err_idx_next   = err_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        if (pop && head.eop)
        begin
            out_valid_next = 1'b1;
            if (pc_step > PC_LIMIT)
            begin
                out_data_next.status      = ST_TOO_LONG;
                out_data_next.error_index = '0;
            end
            else if (disc_step)
            begin
                out_data_next.status      = err_st_step;
                out_data_next.error_index = IDX_W'(err_idx_step);
            end
            else if (ocnt_step != 2'd1)
            begin
                out_data_next.status      = ST_OUT_COUNT;
                out_data_next.error_index = '0;
            end
            else
            begin
                out_data_next.status      = ST_OK;
                out_data_next.error_index = '0;
            end
            // Start the next program from a clean slate.
            mask_next    = '0;
            ocnt_next    = '0;
            pc_next      = '0;
            disc_next    = 1'b0;
            err_st_next  = ST_OK;
            err_idx_next = '0;
        end
        else if (pop)
        begin
            mask_next    = mask_step;
            ocnt_next    = ocnt_step;
            pc_next      = pc_step;
            disc_next    = disc_step;
            err_st_next  = err_st_step;
            err_idx_next = err_idx_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            ocnt_reg      <= '0;
            pc_reg        <= '0;
            disc_reg      <= 1'b0;
            err_st_reg    <= ST_OK;
            err_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            ocnt_reg      <= ocnt_next;
            pc_reg        <= pc_next;
            disc_reg      <= disc_next;
            err_st_reg    <= err_st_next;
            err_idx_reg   <= err_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
